// ===== src/swsd_pkg.sv =====
// Package for the sliding window spread detector.
// Holds default sizes, register widths and codes; no dependencies.
`default_nettype none
package swsd_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int POSITION_BITS = 20;

  localparam int WLEN_BITS      = 7;
  localparam int TOL_BITS       = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE  = 1'd1;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_NONE  = 1'b1;

endpackage
`default_nettype wire

// ===== src/swsd_cell.sv =====
// One cell of the window chain: running max and min of the newest samples.
// Takes its default width from swsd_pkg; instantiated by swsd_chain.
`default_nettype none
module swsd_cell #(
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [SAMPLE_BITS-1:0] prev_hi,
  input  wire logic [SAMPLE_BITS-1:0] prev_lo,
  output logic      [SAMPLE_BITS-1:0] hi,
  output logic      [SAMPLE_BITS-1:0] lo
);

  always_ff @(posedge clk) begin
    if (en) begin
      hi <= (prev_hi > sample) ? prev_hi : sample;
      lo <= (prev_lo < sample) ? prev_lo : sample;
    end
  end

endmodule
`default_nettype wire

// ===== src/swsd_chain.sv =====
// Row of swsd_cell: cell j holds max and min of the last j+1 samples.
// Depends on swsd_cell and swsd_pkg.
`default_nettype none
module swsd_chain #(
  parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [SAMPLE_BITS-1:0] cell_hi [MAX_WINDOW],
  output logic      [SAMPLE_BITS-1:0] cell_lo [MAX_WINDOW]
);

  logic [SAMPLE_BITS-1:0] feed_hi [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] feed_lo [MAX_WINDOW];

  assign feed_hi[0] = sample;
  assign feed_lo[0] = sample;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign feed_hi[j] = cell_hi[j-1];
      assign feed_lo[j] = cell_lo[j-1];
    end
    swsd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .sample (sample),
      .prev_hi(feed_hi[j]),
      .prev_lo(feed_lo[j]),
      .hi     (cell_hi[j]),
      .lo     (cell_lo[j])
    );
  end

endmodule
`default_nettype wire

// ===== src/swsd_pick.sv =====
// Two-level registered selection of the cell at the window length.
// Depends on swsd_pkg; fed by swsd_chain.
`default_nettype none
module swsd_pick #(
  parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS,
  localparam int IDX_W      = $clog2(MAX_WINDOW)
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [IDX_W-1:0]       sel,
  input  wire logic [SAMPLE_BITS-1:0] cell_hi [MAX_WINDOW],
  input  wire logic [SAMPLE_BITS-1:0] cell_lo [MAX_WINDOW],
  output logic      [SAMPLE_BITS-1:0] hi,
  output logic      [SAMPLE_BITS-1:0] lo
);

  localparam int GB   = IDX_W / 2;
  localparam int G    = 1 << GB;
  localparam int NG   = (MAX_WINDOW + G - 1) / G;
  localparam int GI_W = IDX_W - GB;

  logic [SAMPLE_BITS-1:0] grp_hi [NG];
  logic [SAMPLE_BITS-1:0] grp_lo [NG];
  logic [IDX_W-1:0]       sel_q;
  logic [IDX_W-1:0]       gsel;
  logic [GI_W-1:0]        g_idx;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [IDX_W-1:0]       cidx;
    logic [SAMPLE_BITS-1:0] hi_next;
    logic [SAMPLE_BITS-1:0] lo_next;

    always_comb begin
      cidx = IDX_W'(g * G) + (sel & IDX_W'(G - 1));
      if ({1'b0, cidx} < (IDX_W + 1)'(MAX_WINDOW)) begin
        hi_next = cell_hi[cidx];
        lo_next = cell_lo[cidx];
      end else begin
        hi_next = '0;
        lo_next = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        grp_hi[g] <= hi_next;
        grp_lo[g] <= lo_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_q <= sel;
    end
  end

  assign gsel  = sel_q >> GB;
  assign g_idx = gsel[GI_W-1:0];
  assign hi    = grp_hi[g_idx];
  assign lo    = grp_lo[g_idx];

endmodule
`default_nettype wire

// ===== src/sliding_window_spread_detector.sv =====
// Top level of the sliding window spread detector.
// Depends on swsd_pkg, swsd_chain and swsd_pick.
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_we               cfg_index, cfg_data
//  in       in         in_valid / in_ready  sample, last_sample
//  out      out        out_valid / out_ready kind, start_position
//
// One transaction per cycle on the input unless a held result stalls it; each
// result passes through the cell row, group select and output register in turn.
// The cell row updates the window max and min for every accepted sample.
// Reset clears counters and pipeline flags; the cell row needs no clearing pass.
// A result held at the output stalls the whole pipeline and drops in_ready.
`default_nettype none
module sliding_window_spread_detector #(
  parameter int MAX_WINDOW    = swsd_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS   = swsd_pkg::SAMPLE_BITS,
  parameter int POSITION_BITS = swsd_pkg::POSITION_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [swsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [swsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [SAMPLE_BITS-1:0]              sample,
  input  wire logic                                last_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     kind,
  output logic      [POSITION_BITS-1:0]            start_position
);

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int WL_B   = swsd_pkg::WLEN_BITS;
  localparam int TOL_B  = swsd_pkg::TOL_BITS;
  localparam int LW     = (LEN_W > WL_B) ? LEN_W : WL_B;
  localparam int CW     = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
  localparam int DW     = (SAMPLE_BITS > TOL_B) ? SAMPLE_BITS : TOL_B;

  typedef struct packed {
    logic                     valid;
    logic                     examine;
    logic                     last;
    logic [POSITION_BITS-1:0] start;
  } tag_t;

  logic [WL_B-1:0]          window_len;
  logic [TOL_B-1:0]         tolerance;
  logic [POSITION_BITS-1:0] sample_count;
  logic [LEN_W-1:0]         fill_count;
  logic                     found_any;

  logic                     en;
  logic                     accept;
  logic [LW-1:0]            wl_ext;
  logic [LEN_W-1:0]         len_eff;
  logic [POSITION_BITS-1:0] count_next;
  logic [LEN_W-1:0]         fill_next;
  logic [CW-1:0]            count_w;
  logic [CW-1:0]            len_w;
  logic [CW-1:0]            start_w;
  tag_t                     tag0;
  tag_t                     tag0_next;
  tag_t                     tag1;
  logic [IDX_W-1:0]         sel0;
  logic [SAMPLE_BITS-1:0]   cell_hi [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]   cell_lo [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]   win_hi;
  logic [SAMPLE_BITS-1:0]   win_lo;
  logic [DW-1:0]            spread;
  logic                     match;
  logic                     none_found;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WL_B'(1);
      tolerance  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swsd_pkg::REG_WINDOW_LEN: window_len <= cfg_data[WL_B-1:0];
        swsd_pkg::REG_TOLERANCE:  tolerance  <= cfg_data[TOL_B-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wl_ext = LW'(window_len);
    if (window_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = wl_ext[LEN_W-1:0];
    end
    count_next = (sample_count != '1) ? sample_count + 1'b1 : sample_count;
    fill_next  = (fill_count < LEN_W'(MAX_WINDOW)) ? fill_count + 1'b1 : fill_count;
    count_w    = CW'(count_next);
    len_w      = CW'(len_eff);
    start_w    = (count_w >= len_w) ? count_w - len_w + CW'(1) : CW'(1);
    tag0_next.valid   = accept;
    tag0_next.examine = fill_next >= len_eff;
    tag0_next.last    = last_sample;
    tag0_next.start   = start_w[POSITION_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      fill_count   <= '0;
    end else if (accept) begin
      if (last_sample) begin
        sample_count <= '0;
        fill_count   <= '0;
      end else begin
        sample_count <= count_next;
        fill_count   <= fill_next;
      end
    end
  end

  swsd_chain #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chain (
    .clk    (clk),
    .en     (accept),
    .sample (sample),
    .cell_hi(cell_hi),
    .cell_lo(cell_lo)
  );

  swsd_pick #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pick (
    .clk    (clk),
    .en     (en),
    .sel    (sel0),
    .cell_hi(cell_hi),
    .cell_lo(cell_lo),
    .hi     (win_hi),
    .lo     (win_lo)
  );

  assign spread     = DW'(win_hi) - DW'(win_lo);
  assign match      = tag1.examine && (spread <= DW'(tolerance));
  assign none_found = tag1.last && !found_any;

  always_ff @(posedge clk) begin
    if (en) begin
      sel0 <= IDX_W'(len_eff - LEN_W'(1));
      tag0.examine <= tag0_next.examine;
      tag0.last    <= tag0_next.last;
      tag0.start   <= tag0_next.start;
      tag1.examine <= tag0.examine;
      tag1.last    <= tag0.last;
      tag1.start   <= tag0.start;
      if (match) begin
        kind           <= swsd_pkg::KIND_MATCH;
        start_position <= tag1.start;
      end else begin
        kind           <= swsd_pkg::KIND_NONE;
        start_position <= '0;
      end
    end
    if (rst) begin
      tag0.valid <= 1'b0;
      tag1.valid <= 1'b0;
      out_valid  <= 1'b0;
      found_any  <= 1'b0;
    end else if (en) begin
      tag0.valid <= tag0_next.valid;
      tag1.valid <= tag0.valid;
      out_valid  <= tag1.valid && (match || none_found);
      if (tag1.valid) begin
        if (tag1.last) begin
          found_any <= 1'b0;
        end else if (match) begin
          found_any <= 1'b1;
        end
      end
    end
  end

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == swsd_pkg::KIND_NONE |-> start_position == '0)
    else $error("none-found result carries a position");

  a_match_pos : assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == swsd_pkg::KIND_MATCH |-> start_position != '0)
    else $error("match result with zero start position");

  a_fill_max : assert property (@(posedge clk) disable iff (rst)
    fill_count <= LEN_W'(MAX_WINDOW))
    else $error("fill count beyond window depth");

  a_stream_clear : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_sample |=> sample_count == '0 && fill_count == '0)
    else $error("stream counters not cleared after last sample");

endmodule
`default_nettype wire

// ===== tb/tb_sliding_window_spread_detector.sv =====
`timescale 1ns / 1ps
// Testbench for sliding_window_spread_detector: directed, random and mid-stream length runs.
// Depends on swsd_pkg and the RTL top level. Predicts every result and checks each one in order.

typedef struct packed {
  logic                                kind;
  logic [swsd_pkg::POSITION_BITS-1:0] start;
} window_report_t;

class spread_tracker;
  logic [swsd_pkg::WLEN_BITS-1:0]     win_len;
  logic [swsd_pkg::TOL_BITS-1:0]      tol;
  logic [swsd_pkg::SAMPLE_BITS-1:0]   ring [swsd_pkg::MAX_WINDOW];
  int unsigned                        head;
  int unsigned                        filled;
  logic [swsd_pkg::POSITION_BITS-1:0] position;
  bit                                 matched;
  window_report_t                     awaited_windows [$];
  int unsigned                        errors;
  int unsigned                        n_samples;
  int unsigned                        n_streams;
  int unsigned                        n_match;
  int unsigned                        n_none;

  function new();
    win_len = 1;
    tol = 0;
    head = 0;
    filled = 0;
    position = 0;
    matched = 0;
    errors = 0;
    n_samples = 0;
    n_streams = 0;
    n_match = 0;
    n_none = 0;
  endfunction

  function void set_reg(logic [swsd_pkg::CFG_INDEX_BITS-1:0] idx,
                        logic [swsd_pkg::CFG_DATA_BITS-1:0] d);
    case (idx)
      swsd_pkg::REG_WINDOW_LEN: win_len = d[swsd_pkg::WLEN_BITS-1:0];
      swsd_pkg::REG_TOLERANCE:  tol = d[swsd_pkg::TOL_BITS-1:0];
      default: ;
    endcase
  endfunction

  function void take_sample(logic [swsd_pkg::SAMPLE_BITS-1:0] s, logic l);
    int unsigned                      len;
    int unsigned                      newest;
    int unsigned                      k;
    logic [swsd_pkg::SAMPLE_BITS-1:0] lo;
    logic [swsd_pkg::SAMPLE_BITS-1:0] hi;
    logic [swsd_pkg::SAMPLE_BITS-1:0] v;
    window_report_t                   rep;
    bit                               hit;
    hit = 0;
    len = win_len;
    if (len == 0) len = 1;
    if (len > swsd_pkg::MAX_WINDOW) len = swsd_pkg::MAX_WINDOW;
    newest = head;
    ring[newest] = s;
    head = (newest + 1) % swsd_pkg::MAX_WINDOW;
    if (filled < swsd_pkg::MAX_WINDOW) filled++;
    if (position != {swsd_pkg::POSITION_BITS{1'b1}}) position++;
    n_samples++;
    if (filled >= len) begin
      lo = s;
      hi = s;
      for (k = 1; k < len; k++) begin
        v = ring[(newest + swsd_pkg::MAX_WINDOW - k) % swsd_pkg::MAX_WINDOW];
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      if (hi - lo <= tol) begin
        rep.kind = swsd_pkg::KIND_MATCH;
        if (position >= len) rep.start = swsd_pkg::POSITION_BITS'(position - len + 1);
        else rep.start = 1;
        awaited_windows.push_back(rep);
        matched = 1;
        hit = 1;
      end
    end
    if (l) begin
      if (!matched && !hit) begin
        rep.kind = swsd_pkg::KIND_NONE;
        rep.start = 0;
        awaited_windows.push_back(rep);
      end
      head = 0;
      filled = 0;
      position = 0;
      matched = 0;
      n_streams++;
    end
  endfunction

  function void compare_result(logic k, logic [swsd_pkg::POSITION_BITS-1:0] p);
    window_report_t want;
    if (awaited_windows.size() == 0) begin
      $error("unexpected result: kind %0d start_position %0d", k, p);
      errors++;
      return;
    end
    want = awaited_windows.pop_front();
    if (k !== want.kind) begin
      $error("kind mismatch: expected %0d, actual %0d", want.kind, k);
      errors++;
    end
    if (p !== want.start) begin
      $error("start_position mismatch: expected %0d, actual %0d", want.start, p);
      errors++;
    end
    if (want.kind == swsd_pkg::KIND_MATCH) n_match++;
    else n_none++;
  endfunction
endclass

module tb_sliding_window_spread_detector;
  localparam int SB            = swsd_pkg::SAMPLE_BITS;
  localparam int OPEN_ITEMS    = 40;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [swsd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [swsd_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [SB-1:0]                       sample = '0;
  logic                                last_sample = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b1;
  logic                                kind;
  logic [swsd_pkg::POSITION_BITS-1:0]  start_position;

  spread_tracker tracker;
  int unsigned   burst_left = 0;
  bit            pace_on = 1'b1;
  int unsigned   n_settings = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_phase = 0;
  int unsigned   stall_mode = 0;

  sliding_window_spread_detector uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .start_position (start_position)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_phase <= $urandom_range(20, 200);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.compare_result(kind, start_position);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("sliding_window_spread_detector test failed");
      $finish;
    end
  end

  task automatic push_sample(input logic [SB-1:0] s, input logic l);
    int unsigned gap;
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    sample <= s;
    last_sample <= l;
    do @(posedge clk); while (!in_ready);
    tracker.take_sample(s, l);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.awaited_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swsd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [swsd_pkg::CFG_DATA_BITS-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic set_window(input int unsigned len, input int unsigned tol);
    drain();
    write_reg(swsd_pkg::REG_WINDOW_LEN, swsd_pkg::CFG_DATA_BITS'(len));
    write_reg(swsd_pkg::REG_TOLERANCE, swsd_pkg::CFG_DATA_BITS'(tol));
    n_settings++;
  endtask

  initial begin
    int unsigned random_items;
    int unsigned phase_items;
    int unsigned phase_target;
    int unsigned len;
    int unsigned eff;
    int unsigned tol;
    int unsigned n;
    int unsigned spread;
    int unsigned base;
    int unsigned i;
    bit          keep_open;
    logic [SB-1:0] s;

    tracker = new();
    random_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: every single sample is a window
    push_sample('0, 1'b0);
    push_sample('1, 1'b1);
    // zero length acts as one
    set_window(0, 0);
    push_sample(16'h1234, 1'b1);
    // oversize length saturates; stream too short gives none found
    set_window(127, 16'hFFFF);
    push_sample(16'd1, 1'b0);
    push_sample(16'd2, 1'b0);
    push_sample(16'd3, 1'b1);
    set_window(4, 0);
    push_sample(16'd7, 1'b0);
    push_sample(16'd7, 1'b0);
    push_sample(16'd7, 1'b0);
    push_sample(16'd8, 1'b1);
    push_sample(16'd5, 1'b0);
    push_sample(16'd5, 1'b0);
    push_sample(16'd5, 1'b0);
    push_sample(16'd5, 1'b1);
    // full-scale spread at widest tolerance, then just outside it
    set_window(3, 16'hFFFF);
    push_sample('0, 1'b0);
    push_sample('1, 1'b0);
    push_sample('0, 1'b1);
    set_window(2, 16'hFFFE);
    push_sample('0, 1'b0);
    push_sample('1, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = swsd_pkg::MAX_WINDOW;
        2: len = 0;
        3: len = $urandom_range(swsd_pkg::MAX_WINDOW + 1, 127);
        4, 5, 6: len = $urandom_range(2, 8);
        default: len = $urandom_range(2, swsd_pkg::MAX_WINDOW);
      endcase
      case ($urandom_range(0, 5))
        0: tol = 0;
        1: tol = 65535;
        2, 3: tol = $urandom_range(0, 40);
        default: tol = $urandom_range(0, 65535);
      endcase
      set_window(len, tol);
      eff = (len == 0) ? 1 : (len > swsd_pkg::MAX_WINDOW) ? swsd_pkg::MAX_WINDOW : len;
      phase_target = $urandom_range(60, 200);
      phase_items = 0;
      while (phase_items < phase_target) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 2 * eff + 6);
        keep_open = (phase_items + n >= phase_target) && ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: spread = tol;
          6, 7: spread = (tol < 65535) ? tol + 1 : tol;
          default: spread = 65535;
        endcase
        base = $urandom_range(0, 65535 - spread);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 19) == 0) s = SB'($urandom_range(0, 65535));
          else s = SB'(base + $urandom_range(0, spread));
          push_sample(s, !keep_open && (i == n - 1));
        end
        phase_items += n;
      end
      random_items += phase_items;
    end

    // hold a stream open, then shift the length mid-stream
    set_window(2, 0);
    pace_on = 1'b0;
    for (i = 0; i < OPEN_ITEMS; i++) push_sample(i[0] ? 16'hA5A5 : 16'h5A5A, 1'b0);
    pace_on = 1'b1;
    set_window(swsd_pkg::MAX_WINDOW, 3);
    for (i = 0; i < 80; i++) push_sample(SB'(1000 + $urandom_range(0, 3)), i == 79);

    drain();
    $display("Covered %0d samples in %0d streams over %0d register settings",
             tracker.n_samples, tracker.n_streams, n_settings);
    $display("Checked %0d window matches and %0d no-match stream ends",
             tracker.n_match, tracker.n_none);
    if (tracker.errors == 0) begin
      $display("sliding_window_spread_detector test passed");
    end else begin
      $display("sliding_window_spread_detector test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/swsd_pkg.sv
src/swsd_cell.sv
src/swsd_chain.sv
src/swsd_pick.sv
src/sliding_window_spread_detector.sv
tb/tb_sliding_window_spread_detector.sv
